// ===== hdl/stbs_pkg.sv =====
// shared constants and control/status types for the sorted table search block
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package stbs_pkg;

  // table geometry
  localparam int DEPTH  = 1024;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int LR_W   = CNT_W + 1;
  localparam int DATA_W = 32;
  localparam int POS_W  = 11;
  localparam int FUNC_W = 2;

  // function codes of an input word
  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_SEARCH = 2'd2;

  // position reported when the key is absent
  localparam logic signed [POS_W-1:0] POS_NONE = '1;

  // controller to datapath commands
  typedef struct packed {
    logic clear;   // empty the table
    logic append;  // write value at the next free slot
    logic load;    // latch key and set up the search range
    logic probe;   // register midpoint and read the table there
    logic step;    // narrow the range after a mismatch
    logic hit;     // report the midpoint
    logic miss;    // report absent
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic empty;   // search range has run out
    logic eq;      // probed entry equals the key
  } sts_t;

endpackage

// ===== hdl/stbs_dp.sv =====
// datapath: table memory, entry count, search range and result register
// depends on stbs_pkg
`timescale 1ns / 1ps

module stbs_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  stbs_pkg::cmd_t                       cmd,
  input  logic signed [stbs_pkg::DATA_W-1:0]   in_value,
  output stbs_pkg::sts_t                       sts,
  output logic signed [stbs_pkg::POS_W-1:0]    out_position
);
  import stbs_pkg::*;

  logic        [DATA_W-1:0] mem [DEPTH];
  logic        [CNT_W-1:0]  count_r, count_nxt;
  logic signed [DATA_W-1:0] key_r;
  logic signed [DATA_W-1:0] rd_r;
  logic signed [LR_W-1:0]   left_r, right_r;
  logic        [ADDR_W-1:0] mid_r;
  logic signed [LR_W-1:0]   diff;
  logic signed [LR_W-1:0]   mid_full;
  logic        [ADDR_W-1:0] mid_addr;
  logic signed [LR_W-1:0]   mid_ext;
  logic signed [POS_W-1:0]  pos_r;
  logic                     full;

  // table full when every slot holds an entry
  assign full = (count_r == CNT_W'(DEPTH));

  // midpoint of the current range, left + (right - left) / 2
  assign diff     = right_r - left_r;
  assign mid_full = left_r + (diff >>> 1);
  assign mid_addr = mid_full[ADDR_W-1:0];
  assign mid_ext  = signed'({{(LR_W-ADDR_W){1'b0}}, mid_r});

  // status back to the controller
  assign sts.empty = (right_r < left_r);
  assign sts.eq    = (rd_r == key_r);

  // entry count
  always_comb begin
    count_nxt = count_r;
    if (cmd.clear) begin
      count_nxt = '0;
    end else if (cmd.append && !full) begin
      count_nxt = count_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // table memory, one write or one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.append && !full) begin
      mem[count_r[ADDR_W-1:0]] <= in_value;
    end
    if (cmd.probe) begin
      rd_r <= mem[mid_addr];
    end
  end

  // key, search range and midpoint
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r   <= in_value;
      left_r  <= '0;
      right_r <= signed'({1'b0, count_r}) - LR_W'(1);
    end
    if (cmd.probe) begin
      mid_r <= mid_addr;
    end
    if (cmd.step) begin
      if (rd_r < key_r) begin
        left_r <= mid_ext + LR_W'(1);
      end else begin
        right_r <= mid_ext - LR_W'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.hit) begin
      pos_r <= signed'({{(POS_W-ADDR_W){1'b0}}, mid_r});
    end else if (cmd.miss) begin
      pos_r <= POS_NONE;
    end
  end

  assign out_position = pos_r;

endmodule

// ===== hdl/stbs_ctrl.sv =====
// controller: decodes input words and sequences the probes of a search
// depends on stbs_pkg
`timescale 1ns / 1ps

module stbs_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [stbs_pkg::FUNC_W-1:0]   in_func,
  input  stbs_pkg::sts_t                sts,
  output stbs_pkg::cmd_t                cmd,
  output logic                          busy,
  output logic                          out_valid
);
  import stbs_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_CMP
  } state_t;

  state_t state_r, state_nxt;
  logic   valid_r, valid_nxt;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    valid_nxt = 1'b0;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          unique case (in_func)
            FUNC_CLEAR:  cmd.clear  = 1'b1;
            FUNC_APPEND: cmd.append = 1'b1;
            FUNC_SEARCH: begin
              cmd.load  = 1'b1;
              state_nxt = S_READ;
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        if (sts.empty) begin
          cmd.miss  = 1'b1;
          valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cmd.probe = 1'b1;
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        if (sts.eq) begin
          cmd.hit   = 1'b1;
          valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cmd.step  = 1'b1;
          state_nxt = S_READ;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state and result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = valid_r;

endmodule

// ===== hdl/sorted_table_binary_search.sv =====
// Table of up to 1024 signed 32-bit words with a binary search over them. A word
// is taken at a rising edge with start high and busy low. Busy stays low for clear
// and append. A search alternates between registering a probe address and
// comparing the entry read there, since the single table port has registered read
// data; it ends on a match or when the range runs out, after at most 11 probes for
// a full table. The result is on out_position for one cycle with out_valid high,
// the first cycle with busy low; it cannot be held off, so it must be taken then.
// depends on stbs_pkg, stbs_ctrl, stbs_dp
`timescale 1ns / 1ps

module sorted_table_binary_search (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [stbs_pkg::FUNC_W-1:0]         in_func,
  input  logic signed [stbs_pkg::DATA_W-1:0]  in_value,
  output logic                                out_valid,
  output logic signed [stbs_pkg::POS_W-1:0]   out_position
);
  import stbs_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer
  stbs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_func   (in_func),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // table and search datapath
  stbs_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .in_value     (in_value),
    .sts          (sts),
    .out_position (out_position)
  );

  // a result word always comes with the block back at rest
  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result word while busy");

  // clear, append and unused codes never produce a result word
  a_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_func != FUNC_SEARCH) |=> !out_valid)
    else $error("result word after a non-search word");

  // an accepted search always occupies the block
  a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_func == FUNC_SEARCH) |=> (busy && !out_valid))
    else $error("search did not start");

endmodule

// ===== dv/tb.sv =====
// testbench for sorted_table_binary_search: clear, append and search words with a
// self-contained table predictor and an in-order check of every reported position
// depends on stbs_pkg and sorted_table_binary_search
`timescale 1ns / 1ps

module tb;
  import stbs_pkg::*;

  // func code the block must ignore
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  localparam int    RANDOM_WORDS = 700;
  localparam int    CYCLE_LIMIT  = 800000;
  localparam int    DRAIN_CYCLES = 40;
  localparam longint VAL_MAX     = 64'sd2147483647;
  localparam logic signed [DATA_W-1:0] VAL_MIN_W = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] VAL_MAX_W = 32'sh7fff_ffff;

  logic                       clk;
  logic                       rst_n;
  logic                       start;
  logic                       busy;
  logic [FUNC_W-1:0]          in_func;
  logic signed [DATA_W-1:0]   in_value;
  logic                       out_valid;
  logic signed [POS_W-1:0]    out_position;

  // predicted table contents and fill level
  logic signed [DATA_W-1:0]   model_table [DEPTH];
  int                         model_count;

  logic signed [POS_W-1:0]    pos_expected [$];
  int                         errors;
  int                         cycles;
  int                         burst_left;
  int                         random_words;

  sorted_table_binary_search dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_func     (in_func),
    .in_value    (in_value),
    .out_valid   (out_valid),
    .out_position(out_position)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // midpoint probe over the predicted table, first match in probe order wins
  function automatic logic signed [POS_W-1:0] probe_position(
    input logic signed [DATA_W-1:0] key);
    int lo;
    int hi;
    int mid;
    lo = 0;
    hi = model_count - 1;
    while (hi >= lo) begin
      mid = lo + (hi - lo) / 2;
      if (model_table[mid] == key) return mid[POS_W-1:0];
      if (model_table[mid] < key) lo = mid + 1;
      else hi = mid - 1;
    end
    return POS_NONE;
  endfunction

  // update predicted state for an accepted word, queue a position for searches
  function automatic void apply_word(input logic [FUNC_W-1:0] func,
                                     input logic signed [DATA_W-1:0] value);
    case (func)
      FUNC_CLEAR: model_count = 0;
      FUNC_APPEND: begin
        if (model_count < DEPTH) begin
          model_table[model_count] = value;
          model_count++;
        end
      end
      FUNC_SEARCH: pos_expected.push_back(probe_position(value));
      default: ;
    endcase
  endfunction

  // drive one word at the falling edge, bursts separated by random gaps
  task automatic send_word(input logic [FUNC_W-1:0] func,
                           input logic signed [DATA_W-1:0] value);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
      if (gap > 0) begin
        start = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    start    = 1'b1;
    in_func  = func;
    in_value = value;
    @(posedge clk);
    while (busy) @(posedge clk);
    apply_word(func, value);
  endtask

  // compare each reported position with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      if (pos_expected.size() == 0) begin
        $display("%0t: position with none expected: expected none, actual %0d",
                 $time, out_position);
        errors++;
      end else if (out_position !== pos_expected[0]) begin
        $display("%0t: position mismatch: expected %0d, actual %0d",
                 $time, pos_expected[0], out_position);
        errors++;
        void'(pos_expected.pop_front());
      end else begin
        void'(pos_expected.pop_front());
      end
    end
  end

  // run watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL sorted_table_binary_search");
      $finish;
    end
  end

  // empty table, extreme values, repeats, ignored func, unsorted table
  task automatic test_edge_cases();
    send_word(FUNC_SEARCH, 32'sd0);
    send_word(FUNC_UNUSED, 32'sh5a5a_a5a5);
    send_word(FUNC_APPEND, VAL_MIN_W);
    send_word(FUNC_APPEND, -32'sd1);
    send_word(FUNC_APPEND, 32'sd0);
    send_word(FUNC_APPEND, 32'sd0);
    send_word(FUNC_APPEND, 32'sd0);
    send_word(FUNC_APPEND, VAL_MAX_W);
    send_word(FUNC_SEARCH, VAL_MIN_W);
    send_word(FUNC_SEARCH, VAL_MAX_W);
    send_word(FUNC_SEARCH, 32'sd0);
    send_word(FUNC_SEARCH, -32'sd1);
    send_word(FUNC_SEARCH, 32'sd1);
    send_word(FUNC_SEARCH, VAL_MIN_W + 1);
    send_word(FUNC_CLEAR, 32'sh7fff_ffff);
    send_word(FUNC_SEARCH, VAL_MAX_W);
    // out of order contents still follow the same probe path
    send_word(FUNC_APPEND, 32'sd5);
    send_word(FUNC_APPEND, -32'sd7);
    send_word(FUNC_APPEND, 32'sd3);
    send_word(FUNC_SEARCH, -32'sd7);
    send_word(FUNC_SEARCH, 32'sd5);
    send_word(FUNC_UNUSED, 32'sh8000_0001);
    send_word(FUNC_SEARCH, 32'sd3);
  endtask

  // fill every slot, then appends past the end must be dropped
  task automatic test_full_table();
    logic signed [DATA_W-1:0] v;
    send_word(FUNC_CLEAR, 32'sd0);
    for (int i = 0; i < DEPTH; i++) begin
      v = VAL_MIN_W + i * 32'sd4194304;
      send_word(FUNC_APPEND, v);
    end
    send_word(FUNC_APPEND, VAL_MIN_W);
    send_word(FUNC_APPEND, VAL_MAX_W);
    send_word(FUNC_SEARCH, VAL_MIN_W);
    send_word(FUNC_SEARCH, VAL_MIN_W + (DEPTH - 1) * 32'sd4194304);
    send_word(FUNC_SEARCH, VAL_MIN_W + 511 * 32'sd4194304);
    send_word(FUNC_SEARCH, VAL_MIN_W + 700 * 32'sd4194304 + 1);
    send_word(FUNC_SEARCH, VAL_MAX_W);
    for (int i = 0; i < 6; i++)
      send_word(FUNC_SEARCH, VAL_MIN_W + $urandom_range(0, DEPTH - 1) * 32'sd4194304);
  endtask

  // sessions of clear, ascending appends and searches, with noise mixed in
  task automatic test_random_sessions();
    int n;
    int m;
    int step_max;
    bit unsorted;
    longint acc;
    logic signed [DATA_W-1:0] v;
    logic signed [DATA_W-1:0] key;
    logic signed [DATA_W-1:0] vals [$];
    while (random_words < RANDOM_WORDS) begin
      vals.delete();
      if ($urandom_range(0, 9) != 0) begin
        send_word(FUNC_CLEAR, $urandom);
        random_words++;
      end
      n = ($urandom_range(0, 12) == 0) ? $urandom_range(21, 200) : $urandom_range(0, 20);
      case ($urandom_range(0, 3))
        0: step_max = $urandom_range(0, 2);
        1: step_max = 1000;
        2: step_max = 1 << 24;
        default: step_max = 32'h7fff_ffff;
      endcase
      unsorted = ($urandom_range(0, 9) == 0);
      acc = $signed($urandom);
      for (int i = 0; i < n; i++) begin
        if (unsorted) begin
          v = $urandom;
        end else begin
          v = acc[DATA_W-1:0];
          acc += $urandom_range(0, step_max);
          if (acc > VAL_MAX) acc = VAL_MAX;
        end
        send_word(FUNC_APPEND, v);
        vals.push_back(v);
        random_words++;
        if ($urandom_range(0, 24) == 0) send_word(FUNC_UNUSED, $urandom);
      end
      m = $urandom_range(1, 10);
      for (int i = 0; i < m; i++) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4:
            key = (vals.size() > 0) ? vals[$urandom_range(0, vals.size() - 1)] : $urandom;
          5:
            key = (vals.size() > 0) ? vals[$urandom_range(0, vals.size() - 1)] + 1 : $urandom;
          6:
            key = (vals.size() > 0) ? vals[$urandom_range(0, vals.size() - 1)] - 1 : $urandom;
          7, 8:
            key = $urandom;
          default:
            key = $urandom_range(0, 1) ? VAL_MIN_W : VAL_MAX_W;
        endcase
        send_word(FUNC_SEARCH, key);
        random_words++;
        // occasional stray append breaks the ascending order mid-session
        if ($urandom_range(0, 29) == 0) begin
          send_word(FUNC_APPEND, $urandom);
          random_words++;
        end
        if ($urandom_range(0, 24) == 0) send_word(FUNC_UNUSED, $urandom);
      end
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    start        = 1'b0;
    in_func      = FUNC_CLEAR;
    in_value     = '0;
    model_count  = 0;
    errors       = 0;
    cycles       = 0;
    burst_left   = 0;
    random_words = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_edge_cases();
    test_full_table();
    test_random_sessions();

    @(negedge clk);
    start = 1'b0;
    while (pos_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("PASS sorted_table_binary_search");
    end else begin
      $display("FAIL sorted_table_binary_search");
    end
    $finish;
  end

endmodule
